### rtl/core/msgpk_pkg.sv
// Shared types and constants for the MessagePack token encoder.
`timescale 1ns / 1ps
`default_nettype none
package msgpk_pkg;

	// Token kinds
	typedef enum logic [3:0] {
		CMD_NIL    = 4'd0,
		CMD_FALSE  = 4'd1,
		CMD_TRUE   = 4'd2,
		CMD_UINT   = 4'd3,
		CMD_SINT   = 4'd4,
		CMD_DOUBLE = 4'd5,
		CMD_STR    = 4'd6,
		CMD_ARRAY  = 4'd7,
		CMD_MAP    = 4'd8,
		CMD_RAW    = 4'd9
	} cmd_t;

	// Format bytes
	localparam logic [7:0] MP_NIL     = 8'hc0;
	localparam logic [7:0] MP_FALSE   = 8'hc2;
	localparam logic [7:0] MP_TRUE    = 8'hc3;
	localparam logic [7:0] MP_DOUBLE  = 8'hcb;
	localparam logic [7:0] MP_UINT8   = 8'hcc;
	localparam logic [7:0] MP_UINT16  = 8'hcd;
	localparam logic [7:0] MP_UINT32  = 8'hce;
	localparam logic [7:0] MP_UINT64  = 8'hcf;
	localparam logic [7:0] MP_INT8    = 8'hd0;
	localparam logic [7:0] MP_INT16   = 8'hd1;
	localparam logic [7:0] MP_INT32   = 8'hd2;
	localparam logic [7:0] MP_INT64   = 8'hd3;
	localparam logic [7:0] MP_STR8    = 8'hd9;
	localparam logic [7:0] MP_STR16   = 8'hda;
	localparam logic [7:0] MP_STR32   = 8'hdb;
	localparam logic [7:0] MP_ARRAY16 = 8'hdc;
	localparam logic [7:0] MP_ARRAY32 = 8'hdd;
	localparam logic [7:0] MP_MAP16   = 8'hde;
	localparam logic [7:0] MP_MAP32   = 8'hdf;
	localparam logic [7:0] MP_FIXSTR  = 8'ha0;
	localparam logic [7:0] MP_FIXARR  = 8'h90;
	localparam logic [7:0] MP_FIXMAP  = 8'h80;

	localparam int unsigned MAX_BYTES = 9;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [63:0] number;
		logic [31:0] count;
	} token_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	// Encoded token: bytes left-aligned, first byte out in the top lane
	typedef struct packed {
		logic [8*MAX_BYTES-1:0] bytes;
		logic [3:0]             len;
	} desc_t;

endpackage
`default_nettype wire

### rtl/core/msgpack_token_encoder_core.sv
// Top level of the MessagePack token encoder: front end, queue, byte serializer.
//
// Usage:
//  - Requests enter as one token each (cmd, number, count) on the token port;
//    a request is taken at a rising edge with push high and full low.
//  - Results leave as bytes on the result port; the oldest byte is shown while
//    empty is low and is taken at a rising edge with pop high. result.last
//    marks the final byte of a token's encoding.
//  - Each token yields 1 to 9 bytes (shortest MessagePack form). Token kinds
//    10 to 15 are taken and dropped without output.
//  - A token passes the front register, a queue slot, the shift register and the
//    output register before its first byte is visible.
//  - Throughput: one byte per cycle at the output while pop is high; the bytes
//    of a token leave back to back, and the next token loads on the last byte.
//    The serializer sets the byte rate; the front end takes a new token
//    every cycle while the descriptor queue (FIFO_DEPTH entries) has room.
//  - A stalled receiver (pop low) holds the current byte; the queue then fills
//    and full rises once the front stage also holds a token.
//  - Reset (arst_n low) empties the queue and the output register at once.
`timescale 1ns / 1ps
`default_nettype none
module msgpack_token_encoder_core #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  msgpk_pkg::token_t   token,
	output logic                empty,
	input  wire                 pop,
	output msgpk_pkg::result_t  result
);
	import msgpk_pkg::*;

	logic  fr_valid;
	desc_t fr_desc;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;
	desc_t q_desc;

	// classify and align each token
	msgpk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.token      (token),
		.desc_valid (fr_valid),
		.desc       (fr_desc),
		.desc_full  (q_full)
	);

	// decouples token intake from byte output
	msgpk_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_valid),
		.wr_data (fr_desc),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_desc),
		.empty   (q_empty)
	);

	// one byte per cycle while the receiver keeps up, next token loads on the last byte of the current one
	msgpk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_empty (q_empty),
		.desc       (q_desc),
		.desc_pop   (q_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
`default_nettype wire

### rtl/core/msgpk_front.sv
// Front end: accepts tokens, picks the shortest form and builds the byte string.
`timescale 1ns / 1ps
`default_nettype none
module msgpk_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  msgpk_pkg::token_t    token,
	output logic                 desc_valid,
	output msgpk_pkg::desc_t     desc,
	input  wire                  desc_full
);
	import msgpk_pkg::*;

	logic            valid_s1;
	desc_t           desc_s1;
	logic            take;
	logic            cmd_ok;
	logic            has_pfx;
	logic [7:0]      pfx;
	logic [3:0]      nb;
	logic [63:0]     v;
	logic [63:0]     data_al;
	desc_t           desc_d;

	assign take       = !valid_s1 || !desc_full;
	assign full       = !take;
	assign desc_valid = valid_s1;
	assign desc       = desc_s1;

	always_comb begin
		cmd_ok  = 1'b1;
		has_pfx = 1'b0;
		pfx     = MP_NIL;
		nb      = 4'd1;
		v       = token.number;
		case (token.cmd)
			CMD_NIL:   v = {56'd0, MP_NIL};
			CMD_FALSE: v = {56'd0, MP_FALSE};
			CMD_TRUE:  v = {56'd0, MP_TRUE};
			CMD_UINT, CMD_SINT: begin
				if (token.cmd == CMD_SINT && token.number[63]) begin
					if (&token.number[63:5]) begin
						nb = 4'd1;
					end else if (&token.number[63:7]) begin
						has_pfx = 1'b1; pfx = MP_INT8; nb = 4'd1;
					end else if (&token.number[63:15]) begin
						has_pfx = 1'b1; pfx = MP_INT16; nb = 4'd2;
					end else if (&token.number[63:31]) begin
						has_pfx = 1'b1; pfx = MP_INT32; nb = 4'd4;
					end else begin
						has_pfx = 1'b1; pfx = MP_INT64; nb = 4'd8;
					end
				end else begin
					if (~|token.number[63:7]) begin
						nb = 4'd1;
					end else if (~|token.number[63:8]) begin
						has_pfx = 1'b1; pfx = MP_UINT8; nb = 4'd1;
					end else if (~|token.number[63:16]) begin
						has_pfx = 1'b1; pfx = MP_UINT16; nb = 4'd2;
					end else if (~|token.number[63:32]) begin
						has_pfx = 1'b1; pfx = MP_UINT32; nb = 4'd4;
					end else begin
						has_pfx = 1'b1; pfx = MP_UINT64; nb = 4'd8;
					end
				end
			end
			CMD_DOUBLE: begin
				has_pfx = 1'b1; pfx = MP_DOUBLE; nb = 4'd8;
			end
			CMD_STR: begin
				v = {32'd0, token.count};
				if (~|token.count[31:5]) begin
					v = {56'd0, MP_FIXSTR | {3'd0, token.count[4:0]}};
				end else if (~|token.count[31:8]) begin
					has_pfx = 1'b1; pfx = MP_STR8; nb = 4'd1;
				end else if (~|token.count[31:16]) begin
					has_pfx = 1'b1; pfx = MP_STR16; nb = 4'd2;
				end else begin
					has_pfx = 1'b1; pfx = MP_STR32; nb = 4'd4;
				end
			end
			CMD_ARRAY, CMD_MAP: begin
				v = {32'd0, token.count};
				if (~|token.count[31:4]) begin
					v = {56'd0, ((token.cmd == CMD_MAP) ? MP_FIXMAP : MP_FIXARR)
						| {4'd0, token.count[3:0]}};
				end else if (~|token.count[31:16]) begin
					has_pfx = 1'b1; nb = 4'd2;
					pfx = (token.cmd == CMD_MAP) ? MP_MAP16 : MP_ARRAY16;
				end else begin
					has_pfx = 1'b1; nb = 4'd4;
					pfx = (token.cmd == CMD_MAP) ? MP_MAP32 : MP_ARRAY32;
				end
			end
			CMD_RAW: v = {56'd0, token.number[7:0]};
			default: cmd_ok = 1'b0;
		endcase

		case (nb)
			4'd1:    data_al = {v[7:0], 56'd0};
			4'd2:    data_al = {v[15:0], 48'd0};
			4'd4:    data_al = {v[31:0], 32'd0};
			default: data_al = v;
		endcase

		desc_d.bytes = has_pfx ? {pfx, data_al} : {data_al, 8'd0};
		desc_d.len   = nb + {3'd0, has_pfx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= push && cmd_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (take && push) begin
			desc_s1 <= desc_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/msgpk_fifo.sv
// Small descriptor queue between the front end and the byte serializer.
`timescale 1ns / 1ps
`default_nettype none
module msgpk_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               wr_en,
	input  msgpk_pkg::desc_t  wr_data,
	output logic              full,
	input  wire               rd_en,
	output msgpk_pkg::desc_t  rd_data,
	output logic              empty
);
	import msgpk_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	desc_t              slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

### rtl/core/msgpk_back.sv
// Back end: shifts out one encoded byte per cycle into the result register while the receiver keeps up.
`timescale 1ns / 1ps
`default_nettype none
module msgpk_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               desc_empty,
	input  msgpk_pkg::desc_t  desc,
	output logic              desc_pop,
	output logic              empty,
	input  wire               pop,
	output msgpk_pkg::result_t result
);
	import msgpk_pkg::*;

	logic                    cur_valid_q;
	logic [8*MAX_BYTES-1:0]  sh_q;
	logic [3:0]              rem_q;
	logic                    out_valid_q;
	result_t                 out_q;
	logic                    advance;
	logic                    emit;
	logic                    finishing;

	assign advance   = !out_valid_q || pop;
	assign emit      = advance && cur_valid_q;
	assign finishing = emit && (rem_q == 4'd1);
	assign desc_pop  = !desc_empty && (!cur_valid_q || finishing);
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= cur_valid_q;
			end
			if (desc_pop) begin
				cur_valid_q <= 1'b1;
			end else if (finishing) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte <= sh_q[8*MAX_BYTES-1 -: 8];
			out_q.last     <= (rem_q == 4'd1);
		end
		if (desc_pop) begin
			sh_q  <= desc.bytes;
			rem_q <= desc.len;
		end else if (emit) begin
			sh_q  <= {sh_q[8*MAX_BYTES-9:0], 8'd0};
			rem_q <= rem_q - 4'd1;
		end
	end

endmodule
`default_nettype wire

### rtl/core/msgpk_checker.sv
// Port-level checks for the MessagePack token encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module msgpk_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 full,
	input wire                 empty,
	input wire                 pop,
	input msgpk_pkg::result_t  result
);
	import msgpk_pkg::*;

	// output register is cleared by reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result shown during reset");

	// a waiting byte stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("stalled result changed");

	// inside a token the next byte follows with no gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.last) |=> !empty)
		else $error("gap inside a token");

	// backpressure only arises while the serializer is busy
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("full while no output pending");

endmodule

bind msgpack_token_encoder_core msgpk_checker u_msgpk_checker (.*);
`default_nettype wire

### verif/msgpack_token_encoder_core_tb.sv
// Self-checking testbench for the MessagePack token encoder core.
`timescale 1ns / 1ps
module msgpack_token_encoder_core_tb;
	import msgpk_pkg::*;

	// Clock, reset and the two queue-style ports. Everything starts known.
	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    push   = 1'b0;
	logic    full;
	token_t  token  = '0;
	logic    empty;
	logic    pop    = 1'b0;
	result_t result;

	// Bytes the encoder owes us, oldest first.
	result_t pending_bytes[$];

	int errors        = 0;
	int tokens_sent   = 0;  // requests with a real token kind
	int unused_sent   = 0;  // requests with kinds 10..15, dropped by the block
	int bytes_checked = 0;
	int pop_hold      = 0;  // cycles left before pop is raised again
	bit no_idle       = 1'b0;  // burst mode: neither side inserts gaps

	msgpack_token_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.token  (token),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop in case a byte never shows up or full never drops.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Appends one owed byte at the tail of the queue.
	task automatic queue_byte(input result_t r);
		pending_bytes.insert(pending_bytes.size(), r);
	endtask

	// Expected encoding of one token: optional format byte, then nb bytes of
	// the value, big-endian. Shortest form always wins. Kinds 10..15 give
	// nothing at all.
	task automatic predict_encoding(input token_t t);
		logic        has_fmt;
		logic [7:0]  fmt;
		logic [63:0] val;
		int          nb;
		result_t     r;
		has_fmt = 1'b0;
		fmt     = 8'h00;
		val     = 64'd0;
		nb      = 1;
		if (t.cmd == CMD_UINT || (t.cmd == CMD_SINT && !t.number[63])) begin
			// non-negative signed values share the unsigned ladder
			val = t.number;
			if (t.number <= 64'h7f) begin
				nb = 1;
			end else if (t.number <= 64'hff) begin
				has_fmt = 1'b1; fmt = MP_UINT8; nb = 1;
			end else if (t.number <= 64'hffff) begin
				has_fmt = 1'b1; fmt = MP_UINT16; nb = 2;
			end else if (t.number <= 64'hffff_ffff) begin
				has_fmt = 1'b1; fmt = MP_UINT32; nb = 4;
			end else begin
				has_fmt = 1'b1; fmt = MP_UINT64; nb = 8;
			end
		end else begin
			case (t.cmd)
				CMD_NIL:   val = {56'd0, MP_NIL};
				CMD_FALSE: val = {56'd0, MP_FALSE};
				CMD_TRUE:  val = {56'd0, MP_TRUE};
				CMD_SINT: begin
					val = t.number;
					if (t.number >= 64'hffff_ffff_ffff_ffe0) begin
						nb = 1;  // negative fixint
					end else if (t.number >= 64'hffff_ffff_ffff_ff80) begin
						has_fmt = 1'b1; fmt = MP_INT8; nb = 1;
					end else if (t.number >= 64'hffff_ffff_ffff_8000) begin
						has_fmt = 1'b1; fmt = MP_INT16; nb = 2;
					end else if (t.number >= 64'hffff_ffff_8000_0000) begin
						has_fmt = 1'b1; fmt = MP_INT32; nb = 4;
					end else begin
						has_fmt = 1'b1; fmt = MP_INT64; nb = 8;
					end
				end
				CMD_DOUBLE: begin
					has_fmt = 1'b1; fmt = MP_DOUBLE; val = t.number; nb = 8;
				end
				CMD_STR: begin
					val = {32'd0, t.count};
					if (t.count <= 32'd31) begin
						val = {56'd0, MP_FIXSTR | t.count[7:0]};
					end else if (t.count <= 32'hff) begin
						has_fmt = 1'b1; fmt = MP_STR8; nb = 1;
					end else if (t.count <= 32'hffff) begin
						has_fmt = 1'b1; fmt = MP_STR16; nb = 2;
					end else begin
						has_fmt = 1'b1; fmt = MP_STR32; nb = 4;
					end
				end
				CMD_ARRAY, CMD_MAP: begin
					val = {32'd0, t.count};
					if (t.count <= 32'd15) begin
						val = {56'd0, ((t.cmd == CMD_ARRAY) ? MP_FIXARR : MP_FIXMAP)
							| t.count[7:0]};
					end else if (t.count <= 32'hffff) begin
						has_fmt = 1'b1; nb = 2;
						fmt = (t.cmd == CMD_ARRAY) ? MP_ARRAY16 : MP_MAP16;
					end else begin
						has_fmt = 1'b1; nb = 4;
						fmt = (t.cmd == CMD_ARRAY) ? MP_ARRAY32 : MP_MAP32;
					end
				end
				CMD_RAW:   val = {56'd0, t.number[7:0]};  // high bits ignored
				default:   nb = 0;  // unused kind: dropped silently
			endcase
		end
		if (has_fmt) begin
			r.out_byte = fmt;
			r.last     = 1'b0;
			queue_byte(r);
		end
		for (int i = nb - 1; i >= 0; i--) begin
			r.out_byte = val[8*i +: 8];
			r.last     = (i == 0);
			queue_byte(r);
		end
	endtask

	function automatic token_t tok(input logic [3:0] kind, input logic [63:0] num,
			input logic [31:0] cnt);
		token_t t;
		t.cmd    = kind;
		t.number = num;
		t.count  = cnt;
		return t;
	endfunction

	function automatic logic [63:0] rand_bits64();
		return {$urandom, $urandom};
	endfunction

	// Value confined to a random width that sits on or next to a format
	// boundary; one draw in five is the all-ones value of that width.
	function automatic logic [63:0] sized_value();
		int          w;
		logic [63:0] mask;
		case ($urandom_range(0, 8))
			0:       w = 4;
			1:       w = 5;
			2:       w = 7;
			3:       w = 8;
			4:       w = 15;
			5:       w = 16;
			6:       w = 31;
			7:       w = 32;
			default: w = 64;
		endcase
		mask = (w == 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
		if ($urandom_range(0, 4) == 0)
			return mask;
		return rand_bits64() & mask;
	endfunction

	// One token with random content; fields a kind does not use carry junk.
	function automatic token_t random_token();
		token_t t;
		int     pick;
		t    = tok(CMD_NIL, rand_bits64(), $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			t.cmd = 4'($urandom_range(10, 15));
		end else if (pick < 12) begin
			t.cmd = 4'($urandom_range(CMD_NIL, CMD_TRUE));
		end else if (pick < 30) begin
			t.cmd    = CMD_UINT;
			t.number = sized_value();
		end else if (pick < 50) begin
			t.cmd    = CMD_SINT;
			t.number = sized_value();
			if ($urandom_range(0, 1))
				t.number = ~t.number;  // negative of the same magnitude class
		end else if (pick < 58) begin
			t.cmd = CMD_DOUBLE;
		end else if (pick < 82) begin
			t.cmd   = (pick < 66) ? CMD_STR : (pick < 74) ? CMD_ARRAY : CMD_MAP;
			t.count = 32'(sized_value());
		end else begin
			t.cmd = CMD_RAW;
		end
		return t;
	endfunction

	// Offers one request and returns once it has been taken. push stays high
	// afterwards so back-to-back requests never see a low-high blip in one
	// step; it is lowered by the next gap or by wait_drained.
	task automatic send_token(input token_t t);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		token <= t;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_encoding(t);
		if (t.cmd > CMD_RAW)
			unused_sent++;
		else
			tokens_sent++;
	endtask

	// Sender stops and waits until every owed byte has been popped.
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() != 0) @(posedge clk);
	endtask

	// Receiver side: compares every popped byte with the oldest expected one,
	// then, outside burst mode, draws a random stall before popping again.
	always @(posedge clk) begin
		result_t want;
		int      hold;
		if (arst_n) begin
			if (pop && !empty) begin
				bytes_checked++;
				if (pending_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last=%0b",
						result.out_byte, result.last));
				end else begin
					want = pending_bytes.pop_front();
					if (result.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							result.out_byte, want.out_byte));
					if (result.last !== want.last)
						report_mismatch($sformatf("last %0b on byte %02h, expected %0b",
							result.last, want.out_byte, want.last));
				end
				hold = no_idle ? 0 : $urandom_range(0, 7);
				if (hold > 0) begin
					pop      <= 1'b0;
					pop_hold  = hold;
				end
			end else if (!pop) begin
				if (pop_hold <= 1)
					pop <= 1'b1;
				else
					pop_hold = pop_hold - 1;
			end
		end
	end

	// nil, false, true with junk in the unused fields
	task automatic test_fixed_values();
		send_token(tok(CMD_NIL, rand_bits64(), $urandom));
		send_token(tok(CMD_FALSE, rand_bits64(), $urandom));
		send_token(tok(CMD_TRUE, {64{1'b1}}, {32{1'b1}}));
		wait_drained();
	endtask

	// Edges of positive fixint and the uint 8/16/32/64 forms
	task automatic test_unsigned_forms();
		send_token(tok(CMD_UINT, 64'h7f, $urandom));
		send_token(tok(CMD_UINT, 64'h80, $urandom));
		send_token(tok(CMD_UINT, 64'hffff, $urandom));
		send_token(tok(CMD_UINT, 64'hffff_ffff, $urandom));
		send_token(tok(CMD_UINT, {64{1'b1}}, $urandom));
		wait_drained();
	endtask

	// Negative fixint and the int8, int16, int32 and int64 edges; a non-negative signed value
	// must come out in the unsigned form.
	task automatic test_signed_forms();
		send_token(tok(CMD_SINT, 64'hffff_ffff_ffff_ffe0, $urandom));
		send_token(tok(CMD_SINT, 64'hffff_ffff_ffff_ffdf, $urandom));
		send_token(tok(CMD_SINT, 64'hffff_ffff_ffff_ff7f, $urandom));
		send_token(tok(CMD_SINT, 64'hffff_ffff_ffff_7fff, $urandom));
		send_token(tok(CMD_SINT, 64'h8000_0000_0000_0000, $urandom));
		send_token(tok(CMD_SINT, 64'h7fff_ffff_ffff_ffff, $urandom));
		wait_drained();
	endtask

	// Double bits and a raw byte whose upper bits must be ignored
	task automatic test_double_and_raw();
		send_token(tok(CMD_DOUBLE, {64{1'b1}}, $urandom));
		send_token(tok(CMD_RAW, 64'hffff_ffff_ffff_ff5a, $urandom));
		wait_drained();
	endtask

	// Header tokens: fix forms and each length class boundary
	task automatic test_header_forms();
		send_token(tok(CMD_STR, rand_bits64(), 32'd31));
		send_token(tok(CMD_STR, rand_bits64(), 32'd32));
		send_token(tok(CMD_STR, rand_bits64(), 32'h100));
		send_token(tok(CMD_STR, rand_bits64(), 32'h1_0000));
		send_token(tok(CMD_ARRAY, rand_bits64(), 32'd15));
		send_token(tok(CMD_ARRAY, rand_bits64(), 32'hffff));
		send_token(tok(CMD_MAP, rand_bits64(), 32'd16));
		send_token(tok(CMD_MAP, rand_bits64(), 32'hffff_ffff));
		wait_drained();
	endtask

	// Kinds 10..15 are taken and dropped; a real token right behind them
	// shows nothing leaked out.
	task automatic test_unused_kinds();
		send_token(tok(4'd15, {64{1'b1}}, {32{1'b1}}));
		send_token(tok(4'd10, rand_bits64(), $urandom));
		send_token(tok(CMD_NIL, 64'd0, 32'd0));
		wait_drained();
	endtask

	// Preorder sequences half the time: a string header and its payload bytes, or
	// an array header and its elements; the rest single tokens of any kind.
	// Phases switch between random gaps and full-speed bursts, with one full
	// drain at the third phase change.
	task automatic test_random_stream(input int n_items);
		int     target;
		int     len;
		int     phase;
		token_t t;
		target = tokens_sent + n_items;
		phase  = 0;
		while (tokens_sent < target) begin
			if (tokens_sent >= target - n_items + 40 * (phase + 1)) begin
				phase++;
				no_idle = (phase % 3 == 1);
				if (phase == 3)
					wait_drained();
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					len = $urandom_range(0, 6);
					send_token(tok(CMD_STR, rand_bits64(), len));
					repeat (len) send_token(tok(CMD_RAW, rand_bits64(), $urandom));
				end
				3, 4: begin
					len = $urandom_range(0, 5);
					send_token(tok(CMD_ARRAY, rand_bits64(), len));
					repeat (len) begin
						t = random_token();
						send_token(t);
					end
				end
				default: begin
					t = random_token();
					send_token(t);
				end
			endcase
		end
		no_idle = 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fixed_values();
		test_unsigned_forms();
		test_signed_forms();
		test_double_and_raw();
		test_header_forms();
		test_unused_kinds();
		test_random_stream(200);

		// a dropped token could still be in flight; give it time to misbehave
		repeat (12) @(posedge clk);

		$display("covered %0d tokens of all ten kinds plus %0d of unused kinds,",
			tokens_sent, unused_sent);
		$display("%0d encoded bytes checked under random and burst flow control",
			bytes_checked);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
